// ===== rtl/fdc_pkg.sv =====
package fdc_pkg;

    localparam int NUM_DRIVES     = 4;
    localparam int DRIVE_SLOTS    = 4;
    localparam int REG_FILE_DEPTH = 16;
    localparam int RESULT_DEPTH   = 16;

    localparam int CMD_IDX_W   = $clog2(REG_FILE_DEPTH);
    localparam int CMD_CNT_W   = $clog2(REG_FILE_DEPTH + 1);
    localparam int RES_IDX_W   = $clog2(RESULT_DEPTH);
    localparam int CFG_INDEX_W = 1;

    // Bus access kinds.
    localparam logic [2:0] KIND_DATA_WRITE  = 3'd0;
    localparam logic [2:0] KIND_DATA_READ   = 3'd1;
    localparam logic [2:0] KIND_STATUS_READ = 3'd2;
    localparam logic [2:0] KIND_DOR_WRITE   = 3'd3;
    localparam logic [2:0] KIND_CMD_TIMER   = 3'd4;
    localparam logic [2:0] KIND_RESET_TIMER = 3'd5;
    localparam logic [2:0] KIND_DIR_READ    = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_FLAGS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEDIA_MASK  = 1'b1;

    localparam logic [31:0] DRIVE_FLAGS_RESET = 32'h8080_8020;

    // Opcodes with a handler.
    localparam logic [4:0] OP_READ_TRACK    = 5'h02;
    localparam logic [4:0] OP_SPECIFY       = 5'h03;
    localparam logic [4:0] OP_SENSE_DRIVE   = 5'h04;
    localparam logic [4:0] OP_WRITE_DATA    = 5'h05;
    localparam logic [4:0] OP_READ_DATA     = 5'h06;
    localparam logic [4:0] OP_RECALIBRATE   = 5'h07;
    localparam logic [4:0] OP_SENSE_INT     = 5'h08;
    localparam logic [4:0] OP_WRITE_DELETED = 5'h09;
    localparam logic [4:0] OP_READ_ID       = 5'h0a;
    localparam logic [4:0] OP_READ_DELETED  = 5'h0c;
    localparam logic [4:0] OP_FORMAT_TRACK  = 5'h0d;
    localparam logic [4:0] OP_SEEK          = 5'h0f;
    localparam logic [4:0] OP_SCAN_EQUAL    = 5'h11;
    localparam logic [4:0] OP_VERIFY        = 5'h16;
    localparam logic [4:0] OP_SCAN_LOW      = 5'h19;
    localparam logic [4:0] OP_SCAN_HIGH     = 5'h1d;

    // Main status, ST0, ST2 and drive flag bits.
    localparam logic [7:0] MSR_RQM      = 8'h80;
    localparam logic [7:0] MSR_DIO      = 8'h40;
    localparam logic [7:0] MSR_BUSY     = 8'h10;
    localparam logic [7:0] ST0_IC_MASK  = 8'h80 | 8'h40;
    localparam logic [7:0] ST0_INVALID  = 8'h80;
    localparam logic [7:0] ST0_SEEK_END = 8'h10;
    localparam logic [7:0] ST0_NOT_RDY  = 8'h08;
    localparam logic [7:0] ST2_SCAN_HIT = 8'h08;
    localparam logic [7:0] FLAGS_ABSENT = 8'h80;

    localparam logic [3:0] CMD_LEN [32] = '{
        4'd1, 4'd1, 4'd3, 4'd3, 4'd1, 4'd9, 4'd9, 4'd2,
        4'd1, 4'd9, 4'd2, 4'd1, 4'd9, 4'd6, 4'd1, 4'd3,
        4'd1, 4'd9, 4'd1, 4'd1, 4'd1, 4'd1, 4'd9, 4'd1,
        4'd1, 4'd9, 4'd1, 4'd1, 4'd1, 4'd9, 4'd1, 4'd1
    };

    localparam logic [3:0] RES_LEN [32] = '{
        4'd1, 4'd1, 4'd7, 4'd0, 4'd1, 4'd7, 4'd7, 4'd0,
        4'd2, 4'd7, 4'd7, 4'd1, 4'd7, 4'd7, 4'd1, 4'd0,
        4'd1, 4'd7, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7, 4'd1,
        4'd1, 4'd7, 4'd1, 4'd1, 4'd1, 4'd7, 4'd1, 4'd1
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_byte;
    } fdc_req_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_pulse;
    } fdc_rsp_t;

    function automatic logic known_opcode(input logic [4:0] op);
        logic known;
        known = 1'b0;
        case (op)
            OP_READ_TRACK, OP_SPECIFY, OP_SENSE_DRIVE, OP_WRITE_DATA, OP_READ_DATA,
            OP_RECALIBRATE, OP_SENSE_INT, OP_WRITE_DELETED, OP_READ_ID,
            OP_READ_DELETED, OP_FORMAT_TRACK, OP_SEEK, OP_SCAN_EQUAL, OP_VERIFY,
            OP_SCAN_LOW, OP_SCAN_HIGH: known = 1'b1;
            default: known = 1'b0;
        endcase
        return known;
    endfunction

endpackage

// ===== rtl/floppy_controller_register_interface_core.sv =====
// Bus-side register block of a 765-style floppy controller. Every request (data port
// write or read, main status read, DOR write, DIR read, command timer or reset timer
// expiry) gives exactly one response, which appears in the output register on the cycle
// after the request is accepted. A new request is taken every cycle as long as the output
// register is empty or being drained in that cycle, so the sustained rate is one request
// per clock; the only limit is the single output register. Configuration writes (drive
// flags, media mask) are accepted at any time but must only be issued while the block is
// idle. There is no clearing pass after reset.
module floppy_controller_register_interface_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fdc_pkg::fdc_req_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output fdc_pkg::fdc_rsp_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);

    logic [31:0] drive_flags_reg;
    logic [3:0]  media_mask_reg;

    logic [7:0]                      main_status_reg, main_status_next;
    logic [7:0]                      cmd_bytes_reg [fdc_pkg::REG_FILE_DEPTH];
    logic [7:0]                      cmd_bytes_next [fdc_pkg::REG_FILE_DEPTH];
    logic [7:0]                      res_bytes_reg [fdc_pkg::RESULT_DEPTH];
    logic [7:0]                      res_bytes_next [fdc_pkg::RESULT_DEPTH];
    logic [fdc_pkg::CMD_CNT_W-1:0]   cmd_wr_idx_reg, cmd_wr_idx_next;
    logic [fdc_pkg::RES_IDX_W-1:0]   res_rd_idx_reg, res_rd_idx_next;
    logic [3:0]                      bytes_left_reg, bytes_left_next;
    logic                            cmd_delay_reg, cmd_delay_next;
    logic                            cmd_pending_reg, cmd_pending_next;
    logic                            reset_irq_reg, reset_irq_next;
    logic [7:0]                      track_reg [fdc_pkg::DRIVE_SLOTS];
    logic [7:0]                      track_next [fdc_pkg::DRIVE_SLOTS];
    logic                            head_reg [fdc_pkg::DRIVE_SLOTS];
    logic                            head_next [fdc_pkg::DRIVE_SLOTS];
    logic [7:0]                      sector_reg [fdc_pkg::DRIVE_SLOTS];
    logic [7:0]                      sector_next [fdc_pkg::DRIVE_SLOTS];
    logic [1:0]                      sel_drive_reg, sel_drive_next;
    logic                            enabled_reg, enabled_next;
    logic                            dma_mode_reg, dma_mode_next;
    logic [3:0]                      motor_reg, motor_next;

    logic                            out_valid_reg;
    fdc_pkg::fdc_rsp_t               out_data_reg;
    fdc_pkg::fdc_rsp_t               rsp;

    logic                            accept;
    logic [4:0]                      wr_op;
    logic [4:0]                      ex_op;
    logic [1:0]                      drv;
    logic                            drv_media;
    logic [7:0]                      drv_flags;
    logic [7:0]                      st3;
    logic [7:0]                      ms_exec;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign wr_op = in_data.write_byte[4:0];
    assign ex_op = cmd_bytes_reg[0][4:0];
    assign drv   = sel_drive_reg;

    assign drv_media = (32'(drv) < 32'(fdc_pkg::NUM_DRIVES)) && media_mask_reg[drv];
    assign drv_flags = (32'(drv) < 32'(fdc_pkg::NUM_DRIVES)) ?
                       drive_flags_reg[8*drv +: 8] : fdc_pkg::FLAGS_ABSENT;
    assign st3 = {drv_flags[7], drv_flags[6], drv_flags[5], (track_reg[drv] == 8'd0),
                  drv_flags[3], head_reg[drv], drv};
    assign ms_exec = main_status_reg | fdc_pkg::MSR_RQM;

    always_comb
    begin
        main_status_next = main_status_reg;
        cmd_bytes_next   = cmd_bytes_reg;
        res_bytes_next   = res_bytes_reg;
        cmd_wr_idx_next  = cmd_wr_idx_reg;
        res_rd_idx_next  = res_rd_idx_reg;
        bytes_left_next  = bytes_left_reg;
        cmd_delay_next   = cmd_delay_reg;
        cmd_pending_next = cmd_pending_reg;
        reset_irq_next   = reset_irq_reg;
        track_next       = track_reg;
        head_next        = head_reg;
        sector_next      = sector_reg;
        sel_drive_next   = sel_drive_reg;
        enabled_next     = enabled_reg;
        dma_mode_next    = dma_mode_reg;
        motor_next       = motor_reg;
        rsp.read_byte    = 8'd0;
        rsp.irq_pulse    = 1'b0;

        case (in_data.kind)
            fdc_pkg::KIND_DATA_WRITE:
            begin
                if (bytes_left_reg == 4'd0)
                begin
                    // First byte of a command: the opcode sets the expected length.
                    cmd_wr_idx_next = '0;
                    bytes_left_next = fdc_pkg::CMD_LEN[wr_op];
                    if (!fdc_pkg::known_opcode(wr_op))
                    begin
                        res_bytes_next[0] = fdc_pkg::ST0_INVALID;
                    end
                    else if (wr_op != fdc_pkg::OP_SENSE_INT)
                    begin
                        res_bytes_next[0] = 8'd0;
                        if (wr_op == fdc_pkg::OP_READ_DATA)
                        begin
                            res_bytes_next[1] = 8'd0;
                            res_bytes_next[2] = 8'd0;
                        end
                    end
                    cmd_delay_next = (wr_op != fdc_pkg::OP_SPECIFY);
                end
                else
                begin
                    cmd_delay_next = 1'b1;
                end
                if (cmd_wr_idx_next < fdc_pkg::CMD_CNT_W'(fdc_pkg::REG_FILE_DEPTH))
                begin
                    cmd_bytes_next[cmd_wr_idx_next[fdc_pkg::CMD_IDX_W-1:0]] =
                        in_data.write_byte;
                    cmd_wr_idx_next = cmd_wr_idx_next + 1'b1;
                end
                main_status_next = (main_status_reg | fdc_pkg::MSR_RQM) &
                                   ~(fdc_pkg::MSR_DIO | fdc_pkg::MSR_BUSY);
                bytes_left_next = bytes_left_next - 4'd1;
                if (bytes_left_next == 4'd0 && cmd_delay_next)
                begin
                    main_status_next = (main_status_next & ~fdc_pkg::MSR_RQM) |
                                       fdc_pkg::MSR_DIO | fdc_pkg::MSR_BUSY;
                    cmd_pending_next = 1'b1;
                end
            end
            fdc_pkg::KIND_DATA_READ:
            begin
                if (bytes_left_reg != 4'd0)
                begin
                    rsp.read_byte   = res_bytes_reg[res_rd_idx_reg];
                    res_rd_idx_next = res_rd_idx_reg + 1'b1;
                    bytes_left_next = bytes_left_reg - 4'd1;
                    if (bytes_left_next == 4'd0)
                    begin
                        main_status_next = (main_status_reg & ~(fdc_pkg::MSR_RQM |
                                           fdc_pkg::MSR_DIO | fdc_pkg::MSR_BUSY)) |
                                           fdc_pkg::MSR_RQM;
                    end
                end
            end
            fdc_pkg::KIND_STATUS_READ:
            begin
                rsp.read_byte = main_status_reg;
            end
            fdc_pkg::KIND_DOR_WRITE:
            begin
                if (!enabled_reg && in_data.write_byte[2])
                begin
                    reset_irq_next = 1'b1;
                end
                motor_next     = in_data.write_byte[7:4];
                dma_mode_next  = in_data.write_byte[3];
                enabled_next   = in_data.write_byte[2];
                sel_drive_next = in_data.write_byte[1:0];
                if (in_data.write_byte[2])
                begin
                    if (in_data.write_byte[3])
                        main_status_next = main_status_reg & ~fdc_pkg::MSR_BUSY;
                    else
                        main_status_next = main_status_reg | fdc_pkg::MSR_BUSY;
                end
                else
                begin
                    // A cleared enable bit reinitialises status, indexes and results.
                    main_status_next = fdc_pkg::MSR_RQM;
                    for (int i = 0; i < fdc_pkg::RESULT_DEPTH; i++)
                    begin
                        res_bytes_next[i] = 8'd0;
                    end
                    res_bytes_next[0] = fdc_pkg::ST0_IC_MASK;
                    bytes_left_next   = 4'd0;
                    cmd_wr_idx_next   = '0;
                    res_rd_idx_next   = '0;
                end
            end
            fdc_pkg::KIND_CMD_TIMER:
            begin
                if (cmd_pending_reg)
                begin
                    cmd_pending_next = 1'b0;
                    rsp.irq_pulse    = 1'b1;
                    res_rd_idx_next  = '0;
                    bytes_left_next  = fdc_pkg::RES_LEN[ex_op];
                    if (bytes_left_next != 4'd0)
                        main_status_next = ms_exec | fdc_pkg::MSR_DIO | fdc_pkg::MSR_BUSY;
                    else
                        main_status_next = ms_exec & ~(fdc_pkg::MSR_DIO | fdc_pkg::MSR_BUSY);
                    reset_irq_next = 1'b0;

                    unique case (ex_op)
                        fdc_pkg::OP_READ_TRACK, fdc_pkg::OP_SPECIFY, fdc_pkg::OP_VERIFY:
                        begin
                            res_bytes_next[0] = res_bytes_reg[0] & ~fdc_pkg::ST0_IC_MASK;
                            res_bytes_next[1] = 8'd0;
                        end
                        fdc_pkg::OP_SENSE_DRIVE:
                        begin
                            res_bytes_next[7] = st3;
                            res_bytes_next[8] = track_reg[drv];
                            res_rd_idx_next   = fdc_pkg::RES_IDX_W'(7);
                        end
                        fdc_pkg::OP_WRITE_DATA, fdc_pkg::OP_READ_DATA,
                        fdc_pkg::OP_WRITE_DELETED, fdc_pkg::OP_READ_DELETED:
                        begin
                            res_bytes_next[0] = res_bytes_reg[0] & ~fdc_pkg::ST0_IC_MASK;
                            res_bytes_next[1] = 8'd0;
                            res_bytes_next[2] = 8'd0;
                            head_next[drv]    = cmd_bytes_reg[1][2];
                            sector_next[drv]  = cmd_bytes_reg[4];
                        end
                        fdc_pkg::OP_RECALIBRATE:
                        begin
                            res_bytes_next[0] = res_bytes_reg[0] & ~fdc_pkg::ST0_IC_MASK;
                            track_next[drv]   = 8'd0;
                        end
                        fdc_pkg::OP_SENSE_INT:
                        begin
                            res_bytes_next[1] = track_reg[drv];
                        end
                        fdc_pkg::OP_READ_ID:
                        begin
                            res_bytes_next[0] = res_bytes_reg[0] & ~fdc_pkg::ST0_IC_MASK;
                            res_bytes_next[1] = 8'd0;
                            res_bytes_next[2] = 8'd0;
                        end
                        fdc_pkg::OP_FORMAT_TRACK:
                        begin
                            res_bytes_next[0] = res_bytes_reg[0] & ~fdc_pkg::ST0_IC_MASK;
                            res_bytes_next[1] = 8'd0;
                            res_bytes_next[2] = 8'd0;
                            head_next[drv]    = cmd_bytes_reg[1][2];
                        end
                        fdc_pkg::OP_SEEK:
                        begin
                            res_bytes_next[0] = (res_bytes_reg[0] & ~fdc_pkg::ST0_IC_MASK) |
                                                (drv_media ? fdc_pkg::ST0_SEEK_END :
                                                             fdc_pkg::ST0_NOT_RDY);
                            res_bytes_next[1] = 8'd0;
                            head_next[drv]    = cmd_bytes_reg[1][2];
                            track_next[drv]   = cmd_bytes_reg[2];
                        end
                        fdc_pkg::OP_SCAN_EQUAL, fdc_pkg::OP_SCAN_LOW, fdc_pkg::OP_SCAN_HIGH:
                        begin
                            res_bytes_next[0] = res_bytes_reg[0] & ~fdc_pkg::ST0_IC_MASK;
                            res_bytes_next[1] = 8'd0;
                            res_bytes_next[2] = res_bytes_reg[2] | fdc_pkg::ST2_SCAN_HIT;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (!drv_media)
                        res_bytes_next[0] = res_bytes_next[0] | fdc_pkg::ST0_NOT_RDY;
                    res_bytes_next[3] = track_next[drv];
                    res_bytes_next[4] = {7'd0, head_next[drv]};
                    res_bytes_next[5] = sector_next[drv];
                    res_bytes_next[6] = cmd_bytes_reg[5];
                end
            end
            fdc_pkg::KIND_RESET_TIMER:
            begin
                if (reset_irq_reg)
                begin
                    reset_irq_next = 1'b0;
                    rsp.irq_pulse  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_flags_reg <= fdc_pkg::DRIVE_FLAGS_RESET;
            media_mask_reg  <= 4'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fdc_pkg::CFG_DRIVE_FLAGS: drive_flags_reg <= cfg_data;
                fdc_pkg::CFG_MEDIA_MASK:  media_mask_reg  <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_status_reg <= 8'd0;
            for (int i = 0; i < fdc_pkg::RESULT_DEPTH; i++)
            begin
                res_bytes_reg[i] <= 8'd0;
            end
            cmd_wr_idx_reg  <= '0;
            res_rd_idx_reg  <= '0;
            bytes_left_reg  <= 4'd0;
            cmd_delay_reg   <= 1'b0;
            cmd_pending_reg <= 1'b0;
            reset_irq_reg   <= 1'b0;
            for (int i = 0; i < fdc_pkg::DRIVE_SLOTS; i++)
            begin
                track_reg[i]  <= 8'd0;
                head_reg[i]   <= 1'b0;
                sector_reg[i] <= 8'd0;
            end
            sel_drive_reg <= 2'd0;
            enabled_reg   <= 1'b0;
            dma_mode_reg  <= 1'b0;
            motor_reg     <= 4'd0;
        end
        else if (accept)
        begin
            main_status_reg <= main_status_next;
            res_bytes_reg   <= res_bytes_next;
            cmd_wr_idx_reg  <= cmd_wr_idx_next;
            res_rd_idx_reg  <= res_rd_idx_next;
            bytes_left_reg  <= bytes_left_next;
            cmd_delay_reg   <= cmd_delay_next;
            cmd_pending_reg <= cmd_pending_next;
            reset_irq_reg   <= reset_irq_next;
            track_reg       <= track_next;
            head_reg        <= head_next;
            sector_reg      <= sector_next;
            sel_drive_reg   <= sel_drive_next;
            enabled_reg     <= enabled_next;
            dma_mode_reg    <= dma_mode_next;
            motor_reg       <= motor_next;
        end
    end

    // The command file holds no meaningful contents until the host writes it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_bytes_reg <= cmd_bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= rsp;
        end
    end

    a_accept_gives_response: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request left no response");

    a_irq_only_on_timer: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.kind != fdc_pkg::KIND_CMD_TIMER &&
        in_data.kind != fdc_pkg::KIND_RESET_TIMER |=> !out_data.irq_pulse)
        else $error("interrupt raised by a bus access");

    a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.kind == fdc_pkg::KIND_DATA_READ && bytes_left_reg == 4'd0
        |=> out_data.read_byte == 8'd0 && $stable(res_rd_idx_reg))
        else $error("data read with no bytes left changed state");

    a_cmd_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_wr_idx_reg <= fdc_pkg::CMD_CNT_W'(fdc_pkg::REG_FILE_DEPTH))
        else $error("command write index ran past the command file");

endmodule
